// ----- rtl/jegd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jegd_pkg
// Shared types and constants for the Exif GPS detector.
// ----------------------------------------------------------------------------
package jegd_pkg;

  localparam int EXIF_BUFFER_BYTES_DEF = 65536;
  localparam int HEAD_LIMIT_BYTES_DEF  = 131072;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_NOT_JPEG = 3'd1;
  localparam logic [2:0] ST_NO_EXIF  = 3'd2;
  localparam logic [2:0] ST_SHORT    = 3'd3;
  localparam logic [2:0] ST_BAD_TIFF = 3'd4;
  localparam logic [2:0] ST_RANGE    = 3'd5;
  localparam logic [2:0] ST_NO_PTR   = 3'd6;
  localparam logic [2:0] ST_NO_POS   = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic       has_gps;
    logic [2:0] status;
  } out_item_t;

  // Walker to parser handoff.
  typedef struct packed {
    logic        start;
    logic        found;
    logic [2:0]  verdict;
    logic [16:0] length;
  } walk_res_t;

endpackage
`default_nettype wire

// ----- rtl/jpeg_exif_gps_detector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jpeg_exif_gps_detector
// Walks a JPEG file head and reports whether its Exif data holds a GPS fix.
// ----------------------------------------------------------------------------
// Usage: bytes of one file head enter on the in_ channel, one item per cycle
// while in_stall is low, with last_byte set on the final byte. Bytes past the
// head limit are dropped. The segment walker takes one accepted byte a cycle
// and writes Exif payload into the buffer memory. On the last byte, one result
// item follows on the out_ channel. When the head holds a complete Exif
// segment, a sequencer reads the TIFF structure through the single buffer read
// port, with a read and a wait state per byte and an evaluate state per field,
// for the header, both counts, the pointer and each IFD entry searched, before
// out_valid rises. Otherwise the verdict is registered in pst_r, pend_r is set,
// and then out_valid rises. in_stall stays high until the result item has been
// taken, so one file head is in flight at a time. Synchronous reset returns the
// walker to start of image; the buffer is not cleared. A stall on out_ holds
// the result and the input.
// ----------------------------------------------------------------------------
module jpeg_exif_gps_detector #(
  parameter int EXIF_BUFFER_BYTES = jegd_pkg::EXIF_BUFFER_BYTES_DEF,
  parameter int HEAD_LIMIT_BYTES = jegd_pkg::HEAD_LIMIT_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire jegd_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output jegd_pkg::out_item_t      out_data
);

  localparam int AW = $clog2(EXIF_BUFFER_BYTES);

  logic [7:0] mem [EXIF_BUFFER_BYTES];
  logic [7:0] rd_q;
  logic wr_en, rd_en, busy, done, acc, pend_r;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [7:0] wr_data;
  logic [2:0] status, pst_r;
  jegd_pkg::walk_res_t wres;

  assign acc = in_valid && !in_stall;
  assign in_stall = busy || pend_r || out_valid;

  jegd_walker #(.BUF_BYTES(EXIF_BUFFER_BYTES), .HEAD_BYTES(HEAD_LIMIT_BYTES)) u_walk (
    .clk, .rst_n, .byte_en(acc), .item(in_data), .res(wres),
    .wr_en, .wr_addr, .wr_data
  );

  jegd_tiff #(.BUF_BYTES(EXIF_BUFFER_BYTES)) u_tiff (
    .clk, .rst_n, .req(wres), .rd_en, .rd_addr, .rd_data(rd_q),
    .busy, .done, .status
  );

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  // A walk that ended without Exif reports its verdict through pend_r and pst_r.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (wres.start && !wres.found) begin
        pend_r <= 1'b1; pst_r <= wres.verdict;
      end else if (pend_r) begin
        pend_r <= 1'b0; out_valid <= 1'b1;
        out_data.status <= pst_r; out_data.has_gps <= 1'b0;
      end else if (done) begin
        out_valid <= 1'b1; out_data.status <= status;
        out_data.has_gps <= status == jegd_pkg::ST_FOUND;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jegd_walker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jegd_walker
// Marker segment walker that stores the first Exif APP1 payload.
// ----------------------------------------------------------------------------
module jegd_walker #(
  parameter int BUF_BYTES = jegd_pkg::EXIF_BUFFER_BYTES_DEF,
  parameter int HEAD_BYTES = jegd_pkg::HEAD_LIMIT_BYTES_DEF,
  localparam int AW = $clog2(BUF_BYTES),
  localparam int PW = $clog2(HEAD_BYTES + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              byte_en,
  input  wire jegd_pkg::in_item_t item,
  output jegd_pkg::walk_res_t    res,
  output logic                   wr_en,
  output logic [AW-1:0]          wr_addr,
  output logic [7:0]             wr_data
);

  localparam logic [3:0] PH_SOI0 = 4'd0, PH_SOI1 = 4'd1, PH_MARK0 = 4'd2,
    PH_MARK1 = 4'd3, PH_LEN0 = 4'd4, PH_LEN1 = 4'd5, PH_SKIP = 4'd6,
    PH_HDR = 4'd7, PH_PAYLOAD = 4'd8, PH_FOUND = 4'd9, PH_STOP = 4'd10,
    PH_NOTJPEG = 4'd11;

  logic [3:0]  ph_r, ph_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [7:0]  mark_r, mark_nxt;
  logic [2:0]  hidx_r, hidx_nxt;
  logic [2:0]  verd_r, verd_nxt;
  logic [16:0] len_r, len_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0] seglen;
  logic [7:0]  sig;
  logic        step;
  logic [7:0]  b;
  logic [PW-1:0] pos_fin;
  logic [3:0]  ph_fin;

  assign b = item.data_byte;
  assign step = byte_en && (pos_r < PW'(HEAD_BYTES));
  assign seglen = {rem_r[7:0], b};

  always_comb begin
    unique case (hidx_r)
      3'd0: sig = 8'h45;
      3'd1: sig = 8'h78;
      3'd2: sig = 8'h69;
      3'd3: sig = 8'h66;
      default: sig = 8'h00;
    endcase
  end

  always_comb begin
    ph_nxt = ph_r; rem_nxt = rem_r; mark_nxt = mark_r; hidx_nxt = hidx_r;
    verd_nxt = verd_r; len_nxt = len_r; pos_nxt = pos_r;
    wr_en = 1'b0; wr_addr = len_r[AW-1:0]; wr_data = b;
    if (step) begin
      pos_nxt = pos_r + 1'b1;
      unique case (ph_r)
        PH_SOI0: if (b == 8'hFF) ph_nxt = PH_SOI1;
                 else begin ph_nxt = PH_NOTJPEG; verd_nxt = jegd_pkg::ST_NOT_JPEG; end
        PH_SOI1: if (b == 8'hD8) ph_nxt = PH_MARK0;
                 else begin ph_nxt = PH_NOTJPEG; verd_nxt = jegd_pkg::ST_NOT_JPEG; end
        PH_MARK0: ph_nxt = (b == 8'hFF) ? PH_MARK1 : PH_STOP;
        PH_MARK1: begin
          mark_nxt = b;
          if (b >= 8'hD0 && b <= 8'hD9) ph_nxt = PH_MARK0;
          else if (b == 8'hDA) ph_nxt = PH_STOP;
          else ph_nxt = PH_LEN0;
        end
        PH_LEN0: begin rem_nxt = {8'h00, b}; ph_nxt = PH_LEN1; end
        PH_LEN1: begin
          if (seglen < 16'd2) ph_nxt = PH_STOP;
          else begin
            rem_nxt = seglen - 16'd2;
            if (rem_nxt == 16'd0) ph_nxt = PH_MARK0;
            else if (mark_r == 8'hE1 && rem_nxt >= 16'd6) begin
              hidx_nxt = 3'd0; ph_nxt = PH_HDR;
            end else ph_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          rem_nxt = rem_r - 1'b1;
          if (rem_nxt == 16'd0) ph_nxt = PH_MARK0;
        end
        PH_HDR: begin
          rem_nxt = rem_r - 1'b1;
          if (hidx_r >= 3'd6 || b != sig)
            ph_nxt = (rem_nxt != 16'd0) ? PH_SKIP : PH_MARK0;
          else begin
            hidx_nxt = hidx_r + 1'b1;
            if (hidx_nxt == 3'd6) begin
              len_nxt = '0;
              ph_nxt = (rem_nxt != 16'd0) ? PH_PAYLOAD : PH_FOUND;
            end
          end
        end
        PH_PAYLOAD: begin
          if (len_r < 17'(BUF_BYTES)) begin
            wr_en = 1'b1; len_nxt = len_r + 1'b1;
          end
          rem_nxt = rem_r - 1'b1;
          if (rem_nxt == 16'd0) ph_nxt = PH_FOUND;
        end
        default: ;
      endcase
    end
    pos_fin = pos_nxt; ph_fin = ph_nxt;
    res.start = byte_en && item.last_byte;
    res.found = (ph_fin == PH_FOUND) && !(pos_fin < PW'(4));
    res.length = len_nxt;
    if (pos_fin < PW'(4) || ph_fin == PH_NOTJPEG) res.verdict = jegd_pkg::ST_NOT_JPEG;
    else res.verdict = verd_nxt;
    if (res.start) begin
      ph_nxt = PH_SOI0; rem_nxt = '0; mark_nxt = '0; hidx_nxt = '0;
      verd_nxt = jegd_pkg::ST_NO_EXIF; len_nxt = '0; pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_SOI0; rem_r <= '0; mark_r <= '0; hidx_r <= '0;
      verd_r <= jegd_pkg::ST_NO_EXIF; len_r <= '0; pos_r <= '0;
    end else begin
      ph_r <= ph_nxt; rem_r <= rem_nxt; mark_r <= mark_nxt; hidx_r <= hidx_nxt;
      verd_r <= verd_nxt; len_r <= len_nxt; pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/jegd_tiff.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jegd_tiff
// Sequencer that reads the TIFF header and IFDs one byte at a time.
// ----------------------------------------------------------------------------
module jegd_tiff #(
  parameter int BUF_BYTES = jegd_pkg::EXIF_BUFFER_BYTES_DEF,
  localparam int AW = $clog2(BUF_BYTES)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire jegd_pkg::walk_res_t req,
  output logic                   rd_en,
  output logic [AW-1:0]          rd_addr,
  input  wire logic [7:0]        rd_data,
  output logic                   busy,
  output logic                   done,
  output logic [2:0]             status
);

  localparam logic [2:0] S_IDLE = 3'd0, S_READ = 3'd1, S_WAIT = 3'd2,
    S_EVAL = 3'd3, S_DONE = 3'd4;
  // Read goals.
  localparam logic [2:0] G_ORDER = 3'd0, G_MAGIC = 3'd1, G_IFD0 = 3'd2,
    G_CNT0 = 3'd3, G_TAG0 = 3'd4, G_PTR = 3'd5, G_CNT1 = 3'd6, G_TAG1 = 3'd7;

  logic [2:0]  st_r, st_nxt, goal_r, goal_nxt, stat_r, stat_nxt;
  logic [16:0] len_r, len_nxt;
  logic [33:0] base_r, base_nxt;   // start address of the multi-byte read
  logic [1:0]  bi_r, bi_nxt, nb_r, nb_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        le_r, le_nxt;
  logic [15:0] cnt_r, cnt_nxt, i_r, i_nxt;
  logic [33:0] ifd_r, ifd_nxt;
  logic [33:0] addr;
  logic [31:0] val;

  assign addr = base_r + 34'(bi_r);
  assign val = (nb_r == 2'd1) ?
    (le_r ? {16'h0, acc_r[7:0], acc_r[15:8]} : {16'h0, acc_r[15:0]}) :
    (le_r ? {acc_r[7:0], acc_r[15:8], acc_r[23:16], acc_r[31:24]} : acc_r);

  always_comb begin
    st_nxt = st_r; goal_nxt = goal_r; stat_nxt = stat_r; len_nxt = len_r;
    base_nxt = base_r; bi_nxt = bi_r; nb_nxt = nb_r; acc_nxt = acc_r;
    le_nxt = le_r; cnt_nxt = cnt_r; i_nxt = i_r; ifd_nxt = ifd_r;
    rd_en = 1'b0; rd_addr = addr[AW-1:0];
    unique case (st_r)
      S_IDLE: if (req.start && req.found) begin
        len_nxt = req.length;
        if (req.length < 17'd8) begin stat_nxt = jegd_pkg::ST_SHORT; st_nxt = S_DONE; end
        else begin
          goal_nxt = G_ORDER; base_nxt = '0; bi_nxt = '0; nb_nxt = 2'd1;
          le_nxt = 1'b0; st_nxt = S_READ;
        end
      end
      S_READ: begin
        // Reads beyond the buffer return zero.
        rd_en = addr < 34'(BUF_BYTES);
        st_nxt = S_WAIT;
      end
      S_WAIT: begin
        acc_nxt = {acc_r[23:0], (addr < 34'(BUF_BYTES)) ? rd_data : 8'h00};
        if (bi_r == nb_r) st_nxt = S_EVAL;
        else begin bi_nxt = bi_r + 1'b1; st_nxt = S_READ; end
      end
      S_EVAL: begin
        bi_nxt = '0; st_nxt = S_READ;
        unique case (goal_r)
          G_ORDER: begin
            if (acc_r[15:0] == 16'h4949) le_nxt = 1'b1;
            if (acc_r[15:0] != 16'h4949 && acc_r[15:0] != 16'h4D4D) begin
              stat_nxt = jegd_pkg::ST_BAD_TIFF; st_nxt = S_DONE;
            end else begin goal_nxt = G_MAGIC; base_nxt = 34'd2; end
          end
          G_MAGIC: if (val[15:0] != 16'd42) begin
            stat_nxt = jegd_pkg::ST_BAD_TIFF; st_nxt = S_DONE;
          end else begin goal_nxt = G_IFD0; base_nxt = 34'd4; nb_nxt = 2'd3; end
          G_IFD0: begin
            ifd_nxt = 34'(val);
            if (34'(val) + 34'd2 > 34'(len_r)) begin
              stat_nxt = jegd_pkg::ST_RANGE; st_nxt = S_DONE;
            end else begin goal_nxt = G_CNT0; base_nxt = 34'(val); nb_nxt = 2'd1; end
          end
          G_CNT0, G_CNT1, G_TAG0, G_TAG1: begin
            if (goal_r == G_CNT0 || goal_r == G_CNT1) begin
              cnt_nxt = val[15:0]; i_nxt = '0;
            end else if (goal_r == G_TAG0 && val[15:0] == 16'h8825) begin
              goal_nxt = G_PTR; base_nxt = base_r + 34'd8; nb_nxt = 2'd3;
            end else if (goal_r == G_TAG1 &&
                         (val[15:0] == 16'h0002 || val[15:0] == 16'h0004)) begin
              stat_nxt = jegd_pkg::ST_FOUND; st_nxt = S_DONE;
            end else i_nxt = i_r + 1'b1;
            if (goal_nxt == goal_r || goal_r == G_CNT0 || goal_r == G_CNT1) begin
              if (st_nxt != S_DONE) begin
                if (goal_r == G_CNT0) goal_nxt = G_TAG0;
                if (goal_r == G_CNT1) goal_nxt = G_TAG1;
              end
            end
          end
          default: begin // G_PTR
            ifd_nxt = 34'(val);
            if (val == 32'd0) begin stat_nxt = jegd_pkg::ST_NO_PTR; st_nxt = S_DONE; end
            else if (34'(val) + 34'd2 > 34'(len_r)) begin
              stat_nxt = jegd_pkg::ST_RANGE; st_nxt = S_DONE;
            end else begin goal_nxt = G_CNT1; base_nxt = 34'(val); nb_nxt = 2'd1; end
          end
        endcase
        // Entry loop bookkeeping: runs after a count or a missed tag.
        if (st_nxt == S_READ && (goal_nxt == G_TAG0 || goal_nxt == G_TAG1)) begin
          if (i_nxt >= cnt_nxt) begin
            stat_nxt = (goal_nxt == G_TAG0) ? jegd_pkg::ST_NO_PTR : jegd_pkg::ST_NO_POS;
            st_nxt = S_DONE;
          end else if (ifd_r + 34'd2 + 34'({i_nxt, 3'b000}) + 34'({i_nxt, 2'b00}) +
                       34'd12 > 34'(len_r)) begin
            stat_nxt = jegd_pkg::ST_RANGE; st_nxt = S_DONE;
          end else begin
            base_nxt = ifd_r + 34'd2 + 34'({i_nxt, 3'b000}) + 34'({i_nxt, 2'b00});
            nb_nxt = 2'd1;
          end
        end
      end
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign busy = st_r != S_IDLE;
  assign done = st_r == S_DONE;
  assign status = stat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; goal_r <= G_ORDER; stat_r <= jegd_pkg::ST_NO_EXIF;
      bi_r <= '0; nb_r <= '0;
    end else begin
      st_r <= st_nxt; goal_r <= goal_nxt; stat_r <= stat_nxt;
      bi_r <= bi_nxt; nb_r <= nb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt; base_r <= base_nxt; acc_r <= acc_nxt;
    le_r <= le_nxt; cnt_r <= cnt_nxt; i_r <= i_nxt; ifd_r <= ifd_nxt;
  end

endmodule
`default_nettype wire
